FILE: rtl/srt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srt_pkg
// Types and constants for the sorted region table.
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam int MAX_REGIONS = 128;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int CNT_W       = $clog2(2 * MAX_REGIONS + 2);
   localparam int COUNT_W     = 8;
   localparam int ADDR_W      = IDX_W + 1;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_BADINDEX = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] range_base;
      logic [63:0] range_size;
      logic [6:0]  entry_index;
   } srt_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [COUNT_W-1:0] region_count;
      logic [63:0]        total_bytes;
      logic [63:0]        entry_start;
      logic [63:0]        entry_length;
   } srt_rsp_type;

endpackage
`default_nettype wire

FILE: rtl/sorted_region_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_region_table
// Disjoint address regions sorted by base, with add, remove and read items.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low; its single result shows
// for one cycle with rsp_valid and cannot be held off. The table lives in one
// memory of two banks: add and remove stream the active bank through a
// registered read, visiting each held region in turn (read, first piece,
// second piece), write the new list into the other bank and flip banks unless
// the table would overflow or an add brings nothing new. A read within the
// count returns the entry after its registered memory read; a read beyond the
// count, a zero-size or an unused item answers straight from idle. No
// clearing pass is needed after reset.
module sorted_region_table
   import srt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire srt_req_type req_item,
   output logic             rsp_valid,
   output srt_rsp_type      rsp_item
);

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_ELA, S_ELB, S_TAIL, S_FLUSH, S_FIN, S_RDWAIT
   } state_type;

   state_type           state_ff;
   logic                bank_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [63:0]         bytes_ff;
   logic [1:0]          cmd_ff;
   logic [63:0]         base_ff, end_ff, pos_ff, sum_ff;
   logic [CNT_W-1:0]    i_ff, n_ff, pieces_ff;
   logic                pend_v_ff;
   logic [63:0]         pend_s_ff, pend_l_ff;
   logic [127:0]        rdata_ff;
   logic                rsp_valid_ff;
   srt_rsp_type         rsp_ff;

   logic [127:0]        region_mem [2 * MAX_REGIONS];

   logic [63:0]  end_in;
   logic         ren, wen;
   logic [ADDR_W-1:0] raddr, waddr;
   logic [63:0]  rb, rl, re, gap_end;
   logic         overlap, emit_v, merge, last_elem, is_add, full;
   logic [63:0]  emit_s, emit_l;

   assign rb        = rdata_ff[127:64];
   assign rl        = rdata_ff[63:0];
   assign re        = rb + rl;
   assign gap_end   = (rb < end_ff) ? rb : end_ff;
   assign overlap   = !(re <= base_ff || rb >= end_ff);
   assign is_add    = (cmd_ff == CMD_ADD);
   assign last_elem = ((i_ff + 1'b1) >= {{(CNT_W-COUNT_W){1'b0}}, count_ff});
   assign end_in    = (req_item.range_size > ~req_item.range_base) ? '1
                      : req_item.range_base + req_item.range_size;

   always_comb begin
      emit_v = 1'b0;
      emit_s = rb;
      emit_l = rl;
      case (state_ff)
         S_ELA: begin
            if (is_add) begin
               emit_v = (pos_ff < end_ff) && (rb > pos_ff);
               emit_s = pos_ff;
               emit_l = gap_end - pos_ff;
            end else if (!overlap) begin
               emit_v = 1'b1;
            end else begin
               emit_v = (rb < base_ff);
               emit_l = base_ff - rb;
            end
         end
         S_ELB: begin
            if (is_add) begin
               emit_v = 1'b1;
            end else begin
               emit_v = overlap && (re > end_ff);
               emit_s = end_ff;
               emit_l = re - end_ff;
            end
         end
         S_TAIL: begin
            emit_v = is_add && (pos_ff < end_ff);
            emit_s = pos_ff;
            emit_l = end_ff - pos_ff;
         end
         default: begin
            emit_v = 1'b0;
         end
      endcase
   end

   assign merge = is_add && pend_v_ff && (pend_s_ff + pend_l_ff == emit_s);
   assign wen   = pend_v_ff && (n_ff < CNT_W'(MAX_REGIONS))
                  && ((emit_v && !merge) || state_ff == S_FLUSH);
   assign waddr = {~bank_ff, n_ff[IDX_W-1:0]};
   assign ren   = (state_ff == S_RD)
                  || (state_ff == S_IDLE && start && req_item.command == CMD_READ);
   assign raddr = (state_ff == S_RD) ? {bank_ff, i_ff[IDX_W-1:0]}
                  : {bank_ff, req_item.entry_index[IDX_W-1:0]};

   always_comb begin
      if (is_add) begin
         full = ({1'b0, {(CNT_W-COUNT_W){1'b0}}, count_ff} + {1'b0, pieces_ff})
                > (CNT_W+1)'(MAX_REGIONS);
      end else begin
         full = n_ff > CNT_W'(MAX_REGIONS);
      end
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         region_mem[waddr] <= {pend_s_ff, pend_l_ff};
      end
      if (ren) begin
         rdata_ff <= region_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bank_ff      <= 1'b0;
         count_ff     <= '0;
         bytes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (emit_v) begin
            sum_ff <= sum_ff + emit_l;
            if ((state_ff == S_ELA || state_ff == S_TAIL) && is_add) begin
               pieces_ff <= pieces_ff + 1'b1;
            end
            if (merge) begin
               pend_l_ff <= pend_l_ff + emit_l;
            end else begin
               pend_s_ff <= emit_s;
               pend_l_ff <= emit_l;
               pend_v_ff <= 1'b1;
               if (pend_v_ff) begin
                  n_ff <= n_ff + 1'b1;
               end
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cmd_ff    <= req_item.command;
                  base_ff   <= req_item.range_base;
                  pos_ff    <= req_item.range_base;
                  end_ff    <= end_in;
                  i_ff      <= '0;
                  n_ff      <= '0;
                  pieces_ff <= '0;
                  sum_ff    <= '0;
                  pend_v_ff <= 1'b0;
                  rsp_ff.region_count <= count_ff;
                  rsp_ff.total_bytes  <= bytes_ff;
                  rsp_ff.entry_start  <= '0;
                  rsp_ff.entry_length <= '0;
                  rsp_ff.status       <= ST_OK;
                  if (req_item.command == CMD_READ) begin
                     if ({1'b0, req_item.entry_index} < count_ff) begin
                        state_ff <= S_RDWAIT;
                     end else begin
                        rsp_ff.status <= ST_BADINDEX;
                        rsp_valid_ff  <= 1'b1;
                     end
                  end else if ((req_item.command == CMD_ADD
                               || req_item.command == CMD_REMOVE)
                               && end_in != req_item.range_base) begin
                     state_ff <= (count_ff == '0) ? S_TAIL : S_RD;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_RDWAIT: begin
               rsp_ff.entry_start  <= rb;
               rsp_ff.entry_length <= rl;
               rsp_valid_ff        <= 1'b1;
               state_ff            <= S_IDLE;
            end
            S_RD: begin
               state_ff <= S_ELA;
            end
            S_ELA: begin
               state_ff <= S_ELB;
            end
            S_ELB: begin
               if (is_add && re > pos_ff) begin
                  pos_ff <= re;
               end
               i_ff     <= i_ff + 1'b1;
               state_ff <= last_elem ? S_TAIL : S_RD;
            end
            S_TAIL: begin
               state_ff <= S_FLUSH;
            end
            S_FLUSH: begin
               if (pend_v_ff) begin
                  n_ff <= n_ff + 1'b1;
               end
               pend_v_ff <= 1'b0;
               state_ff  <= S_FIN;
            end
            S_FIN: begin
               if (full) begin
                  rsp_ff.status <= ST_FULL;
               end else if (!is_add || pieces_ff != '0) begin
                  bank_ff  <= ~bank_ff;
                  count_ff <= n_ff[COUNT_W-1:0];
                  bytes_ff <= sum_ff;
                  rsp_ff.region_count <= n_ff[COUNT_W-1:0];
                  rsp_ff.total_bytes  <= sum_ff;
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_REGIONS))
      else $error("region count above capacity");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted item made no progress");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.region_count == count_ff)
      else $error("reported count differs from held count");

   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == ST_FULL |-> $stable(count_ff))
      else $error("rejected item changed the table");
`endif

endmodule
`default_nettype wire

FILE: dv/tb_sorted_region_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_region_table
// Self-checking bench for the sorted region table.
// ----------------------------------------------------------------------------
// Drives add, remove, read and unused items with random gaps, predicts every
// result from a local copy of the region list and compares field by field.
// ----------------------------------------------------------------------------
module tb_sorted_region_table;
   import srt_pkg::*;

   localparam int WATCHDOG = 20000;

   class region_scoreboard;
      logic [63:0] rs[MAX_REGIONS];
      logic [63:0] rl[MAX_REGIONS];
      int unsigned cnt;
      logic [63:0] total;
      srt_rsp_type pending[$];
      int errors;
      int checked;

      function new();
         cnt = 0; total = 0; errors = 0; checked = 0;
      endfunction

      function logic [1:0] apply_add(logic [63:0] base, logic [63:0] size);
         logic [63:0] ws[$];
         logic [63:0] wl[$];
         logic [63:0] e, p, rb, re, pe, added;
         int unsigned pieces, n;
         e = base + size; p = base; added = 0; pieces = 0;
         for (int i = 0; i < cnt; i++) begin
            rb = rs[i]; re = rb + rl[i];
            if (p < e && rb > p) begin
               pe = (rb < e) ? rb : e;
               ws.push_back(p); wl.push_back(pe - p);
               added += pe - p; pieces++;
            end
            ws.push_back(rb); wl.push_back(rl[i]);
            if (re > p) p = re;
         end
         if (p < e) begin
            ws.push_back(p); wl.push_back(e - p);
            added += e - p; pieces++;
         end
         if (pieces == 0) return ST_OK;
         if (cnt + pieces > MAX_REGIONS) return ST_FULL;
         n = 0;
         foreach (ws[i]) begin
            if (n > 0 && rs[n-1] + rl[n-1] == ws[i]) rl[n-1] += wl[i];
            else begin
               rs[n] = ws[i]; rl[n] = wl[i]; n++;
            end
         end
         cnt = n; total += added;
         return ST_OK;
      endfunction

      function logic [1:0] apply_remove(logic [63:0] base, logic [63:0] size);
         logic [63:0] ws[$];
         logic [63:0] wl[$];
         logic [63:0] e, rb, re, kept, removed;
         e = base + size; removed = 0;
         for (int i = 0; i < cnt; i++) begin
            rb = rs[i]; re = rb + rl[i]; kept = 0;
            if (re <= base || rb >= e) begin
               ws.push_back(rb); wl.push_back(rl[i]);
            end else begin
               if (rb < base) begin
                  ws.push_back(rb); wl.push_back(base - rb); kept += base - rb;
               end
               if (re > e) begin
                  ws.push_back(e); wl.push_back(re - e); kept += re - e;
               end
               removed += rl[i] - kept;
            end
         end
         if (ws.size() > MAX_REGIONS) return ST_FULL;
         foreach (ws[i]) begin
            rs[i] = ws[i]; rl[i] = wl[i];
         end
         cnt = ws.size(); total -= removed;
         return ST_OK;
      endfunction

      function void note_item(srt_req_type it);
         srt_rsp_type r;
         logic [63:0] sz;
         r = '0;
         sz = it.range_size;
         if (sz > ~it.range_base) sz = ~it.range_base;
         r.status = ST_OK;
         if (it.command == CMD_ADD) begin
            if (sz != 0) r.status = apply_add(it.range_base, sz);
         end else if (it.command == CMD_REMOVE) begin
            if (sz != 0) r.status = apply_remove(it.range_base, sz);
         end else if (it.command == CMD_READ) begin
            if (it.entry_index < cnt) begin
               r.entry_start = rs[it.entry_index];
               r.entry_length = rl[it.entry_index];
            end else r.status = ST_BADINDEX;
         end
         r.region_count = cnt[7:0];
         r.total_bytes = total;
         pending.push_back(r);
      endfunction

      function void check_result(srt_rsp_type got);
         srt_rsp_type x;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
         end
         x = pending.pop_front();
         if (got.status !== x.status || got.region_count !== x.region_count ||
             got.total_bytes !== x.total_bytes || got.entry_start !== x.entry_start ||
             got.entry_length !== x.entry_length) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", x, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   srt_req_type req_item = '0;
   logic busy;
   logic rsp_valid;
   srt_rsp_type rsp_item;

   region_scoreboard sb = new();
   int idle_cycles = 0;
   int sent = 0;
   bit quiet = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   sorted_region_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_item(req_item);
         if (rsp_valid) sb.check_result(rsp_item);
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // start stays high after an accepted item until the next item, an idle
   // cycle or a drain takes it over
   task automatic send_item(logic [1:0] cmd, logic [63:0] base, logic [63:0] size,
                            logic [6:0] idx);
      srt_req_type it;
      it.command = cmd; it.range_base = base; it.range_size = size;
      it.entry_index = idx;
      if (!quiet) begin
         while ($urandom_range(99) < 16) begin
            start <= 0;
            @(posedge clock);
         end
      end
      start <= 1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   task automatic wait_drained();
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_item(bit crowd);
      int unsigned pick;
      logic [63:0] b, s;
      pick = $urandom_range(99);
      if (crowd) begin
         b = 64'h1000 + 64'(16 * $urandom_range(400));
         s = 64'($urandom_range(1, 12));
      end else begin
         b = 64'($urandom_range(0, 4000));
         s = 64'($urandom_range(0, 300));
      end
      if (pick < 8) b = rand64();
      if (pick < 4) s = rand64();
      if (pick < 45) send_item(CMD_ADD, b, s, 7'($urandom()));
      else if (pick < 75) send_item(CMD_REMOVE, b, s, 7'($urandom()));
      else if (pick < 97) send_item(CMD_READ, rand64(), rand64(),
                                    7'($urandom_range(0, sb.cnt + 2)));
      else send_item(CMD_UNUSED, rand64(), rand64(), 7'($urandom()));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed part
      send_item(CMD_READ, 0, 0, 0);
      send_item(CMD_ADD, 64'd100, 64'd50, 0);
      send_item(CMD_ADD, 64'd200, 64'd50, 0);
      send_item(CMD_ADD, 64'd150, 64'd50, 0);
      send_item(CMD_ADD, 64'd120, 64'd300, 0);
      send_item(CMD_ADD, 64'd10, 64'd0, 0);
      send_item(CMD_READ, 0, 0, 7'd0);
      send_item(CMD_READ, 0, 0, 7'd127);
      send_item(CMD_REMOVE, 64'd200, 64'd10, 0);
      send_item(CMD_REMOVE, 64'd0, 64'd150, 0);
      send_item(CMD_READ, 0, 0, 7'd1);
      send_item(CMD_ADD, 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      send_item(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'd5, 0);
      send_item(CMD_READ, 0, 0, 7'd2);
      send_item(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'h7F);
      send_item(CMD_REMOVE, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      // fill the table to its limit, then overflow add and splitting remove
      for (int i = 0; i < MAX_REGIONS; i++)
         send_item(CMD_ADD, 64'd1000 + 4 * i, 64'd3, 0);
      send_item(CMD_ADD, 64'd0, 64'd2000, 0);
      send_item(CMD_REMOVE, 64'd1001, 64'd1, 0);
      send_item(CMD_READ, 0, 0, 7'd127);
      send_item(CMD_ADD, 64'd1002, 64'd2, 0);
      send_item(CMD_REMOVE, 64'd1000, 64'd1, 0);
      send_item(CMD_REMOVE, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      wait_drained();
      // random part
      for (int i = 0; i < 450; i++) begin
         quiet = (i >= 200 && i < 300);
         if (i == 400) wait_drained();
         random_item(i >= 300 && i < 500);
      end
      quiet = 0;
      start <= 0;
      while (sb.pending.size() != 0 && idle_cycles < WATCHDOG) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("sent %0d items, checked %0d results, table fill and overflow covered",
               sent, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
         $display("tb: failure");
      end
      $finish;
   end
endmodule

FILE: sorted_region_table.f
rtl/srt_pkg.sv
rtl/sorted_region_table.sv
dv/tb_sorted_region_table.sv
